/* rtl/sbis_pkg.sv */
`default_nettype none

package sbis_pkg;

  localparam int SLOT_W  = 10;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } sbis_op_e;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } sbis_side_e;

endpackage

`default_nettype wire

/* rtl/sbis_if.sv */
`default_nettype none

interface sbis_in_if
  import sbis_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic        [SLOT_W-1:0]       slot;
  logic signed [NUMBER_WIDTH-1:0] number;
  logic                           side;

  modport source (output valid, operation, slot, number, side, input ready);
  modport sink   (input valid, operation, slot, number, side, output ready);
endinterface

interface sbis_out_if
  import sbis_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] interval_index;

  modport source (output valid, interval_index, input ready);
  modport sink   (input valid, interval_index, output ready);
endinterface

`default_nettype wire

/* rtl/sbis_ram.sv */
`default_nettype none

module sbis_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/sbis_ctrl.sv */
`default_nettype none

module sbis_ctrl
  import sbis_pkg::*;
#(
  parameter  int DEPTH        = 1024,
  parameter  int NUMBER_WIDTH = 32,
  localparam int AW           = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [COUNT_W-1:0]      point_count_i,
  sbis_in_if.sink                      in_i,
  sbis_out_if.source                   out_o,
  output logic                         ram_we_o,
  output logic                         ram_re_o,
  output logic      [AW-1:0]           ram_addr_o,
  output logic      [NUMBER_WIDTH-1:0] ram_wdata_o,
  input  wire logic [NUMBER_WIDTH-1:0] ram_rdata_i
);

  localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            low_q, low_d;
  logic [AW-1:0]            high_q, high_d;
  logic [AW-1:0]            mid_q, mid_d;
  logic [AW-1:0]            res_q, res_d;
  logic signed [NUMBER_WIDTH-1:0] number_q, number_d;
  logic                     side_q, side_d;
  logic                     out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]       out_idx_q, out_idx_d;

  logic [CW-1:0]            count_clamped;
  logic [AW-1:0]            top_index;
  logic                     in_fire;
  logic                     slot_ok;
  logic [AW-1:0]            nlow, nhigh;
  logic [AW:0]              span_sum;
  logic                     more;
  logic signed [NUMBER_WIDTH-1:0] probe;

  // clamp point_count to [2, DEPTH]
  always_comb begin
    count_clamped = CW'(point_count_i);
    if (count_clamped < CW'(2)) begin
      count_clamped = CW'(2);
    end else if (count_clamped > CW'(DEPTH)) begin
      count_clamped = CW'(DEPTH);
    end
  end

  assign top_index = AW'(count_clamped - CW'(1));
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_ok    = 32'(in_i.slot) < 32'(DEPTH);
  assign probe      = $signed(ram_rdata_i);

  // next bounds, then the next probe address in the same cycle
  always_comb begin
    nlow  = low_q;
    nhigh = high_q;
    if (state_q == ST_IDLE) begin
      nlow  = '0;
      nhigh = top_index;
    end else if (probe < number_q) begin
      nlow = mid_q;
    end else begin
      nhigh = mid_q;
    end
    span_sum = {1'b0, nlow} + {1'b0, nhigh};
    more     = ({1'b0, nlow} + (AW + 1)'(1)) < {1'b0, nhigh};
  end

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    res_d       = res_q;
    number_d    = number_q;
    side_d      = side_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = span_sum[AW:1];
    ram_wdata_o = in_i.number;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.operation == OP_WRITE) begin
            // writes only land here, so no search read can overlap them
            ram_we_o   = slot_ok;
            ram_addr_o = AW'(in_i.slot);
          end else begin
            number_d = in_i.number;
            side_d   = in_i.side;
            low_d    = nlow;
            high_d   = nhigh;
            if (more) begin
              ram_re_o = 1'b1;
              mid_d    = span_sum[AW:1];
              state_d  = ST_STEP;
            end else begin
              res_d   = nlow;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_STEP: begin
        if (probe == number_q) begin
          res_d   = (side_q == SIDE_RIGHT) ? mid_q : mid_q - AW'(1);
          state_d = ST_DONE;
        end else begin
          low_d  = nlow;
          high_d = nhigh;
          if (more) begin
            ram_re_o = 1'b1;
            mid_d    = span_sum[AW:1];
          end else begin
            res_d   = nlow;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = INDEX_W'(res_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      mid_q       <= '0;
      res_q       <= '0;
      number_q    <= '0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      mid_q       <= mid_d;
      res_q       <= res_d;
      number_q    <= number_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.interval_index = out_idx_q;

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_IDLE && !ram_re_o))
    else $error("breakpoint write during a search");

  a_probe_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (mid_q > low_q && mid_q < high_q))
    else $error("probe outside the open bounds");

  a_read_before_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> $past(ram_re_o))
    else $error("step without a read issued the cycle before");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done state");

endmodule

`default_nettype wire

/* rtl/sorted_breakpoint_interval_search.sv */
`default_nettype none
// channel  dir  payload                             accepted when
// in_i     in   operation, slot, number, side       valid && ready
// out_o    out  interval_index                      valid && ready
// cfg      in   cfg_wdata_i (point_count)           cfg_we_i
//
// A write word is taken and written in the idle state. A query bisects slots 0..N-1,
// N being point_count clamped to 2..DEPTH, one bisection step per cycle, paced by the single
// read port of the breakpoint RAM and its registered read data.
// One word is in work at a time; a finished result waits in the output register
// while the next word is accepted. Reset clears control and sets point_count to 2;
// the RAM is not cleared.

module sorted_breakpoint_interval_search
  import sbis_pkg::*;
#(
  parameter int DEPTH        = 1024,
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  sbis_in_if.sink                 in_i,
  sbis_out_if.source              out_o
);

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_W-1:0]      point_count_q;
  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_addr;
  logic [NUMBER_WIDTH-1:0] ram_wdata;
  logic [NUMBER_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  sbis_ctrl #(
    .DEPTH        (DEPTH),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_count_i (point_count_q),
    .in_i          (in_i),
    .out_o         (out_o),
    .ram_we_o      (ram_we),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ram_rdata_i   (ram_rdata)
  );

  sbis_ram #(
    .WIDTH (NUMBER_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/sorted_breakpoint_interval_search_tb.sv */
`default_nettype none

module sorted_breakpoint_interval_search_tb;
  import sbis_pkg::*;

  localparam int BP_DEPTH  = 1024;
  localparam int NUM_W     = 32;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE    = 20;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_e;

  // Mirror of the breakpoint RAM and point_count; one expectation per query word.
  class interval_scoreboard;
    localparam int SLOTS = 1024;

    typedef struct {
      logic signed [31:0] point;
      sbis_side_e         side;
      logic [9:0]         want;
    } interval_expect_t;

    logic signed [31:0] bp_mirror [SLOTS];
    logic [10:0]        count_reg;
    interval_expect_t   expected_intervals [$];
    int                 writes_seen;
    int                 queries_seen;

    function new();
      foreach (bp_mirror[i]) bp_mirror[i] = '0;
      count_reg    = COUNT_RESET;
      writes_seen  = 0;
      queries_seen = 0;
    endfunction

    function void set_count(logic [10:0] value);
      count_reg = value;
    endfunction

    function int points_in_use();
      if (count_reg < 2) return 2;
      if (count_reg > SLOTS) return SLOTS;
      return int'(count_reg);
    endfunction

    function logic [9:0] predict_interval(logic signed [31:0] point, sbis_side_e side);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = points_in_use() - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (bp_mirror[mid] < point) lo = mid;
        else if (bp_mirror[mid] > point) hi = mid;
        else return (side == SIDE_RIGHT) ? 10'(mid) : 10'(mid - 1);
      end
      return 10'(lo);
    endfunction

    function void note_input(sbis_op_e op, logic [9:0] slot, logic signed [31:0] number,
                             sbis_side_e side);
      interval_expect_t e;
      if (op == OP_WRITE) begin
        bp_mirror[slot] = number;
        writes_seen++;
      end else begin
        e.point = number;
        e.side  = side;
        e.want  = predict_interval(number, side);
        expected_intervals.insert(expected_intervals.size(), e);
        queries_seen++;
      end
    endfunction

    function bit check_result(logic [9:0] got, output string msg);
      interval_expect_t e;
      if (expected_intervals.size() == 0) begin
        msg = $sformatf("interval_index %0d with no query outstanding", got);
        return 1'b0;
      end
      e = expected_intervals.pop_front();
      if (got !== e.want) begin
        msg = $sformatf("point %0d side %s: interval_index %0d, expected %0d",
                        e.point, e.side.name(), got, e.want);
        return 1'b0;
      end
      msg = "";
      return 1'b1;
    endfunction

    function int pending();
      return expected_intervals.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  logic               hold_go;

  sbis_in_if #(.NUMBER_WIDTH(NUM_W)) in_bus ();
  sbis_out_if                        out_bus ();

  sorted_breakpoint_interval_search #(
    .DEPTH       (BP_DEPTH),
    .NUMBER_WIDTH(NUM_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  interval_scoreboard sb;
  int                 mismatch_count = 0;
  int                 burst_left = 0;
  int                 settings_done = 0;
  int                 max_span = 0;
  logic signed [31:0] gen_val [BP_DEPTH];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Run did not finish in time");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.note_input(sbis_op_e'(in_bus.operation), in_bus.slot, in_bus.number,
                    sbis_side_e'(in_bus.side));
  end

  always @(posedge clk_i) begin : result_mon
    string msg;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (!sb.check_result(out_bus.interval_index, msg)) report_mismatch(msg);
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off on request.
  initial begin : sink_pattern
    sink_mode_e mode;
    int         mode_left;
    bit         hold_taken;
    mode       = SINK_OPEN;
    mode_left  = 0;
    hold_taken = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:   out_bus.ready <= 1'b1;
        SINK_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
        default:     out_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // One word per call; valid stays up while a burst lasts.
  task automatic offer(input sbis_op_e op, input logic [SLOT_W-1:0] slot,
                       input logic signed [NUM_W-1:0] number, input sbis_side_e side);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.slot      <= slot;
    in_bus.number    <= number;
    in_bus.side      <= side;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_bus.valid <= 1'b0;
      burst_left = $urandom_range(0, 24);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    if (in_bus.valid) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [COUNT_W-1:0] value);
    quiesce();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_count(value);
    cfg_we_i <= 1'b0;
    settings_done++;
    if (sb.points_in_use() > max_span) max_span = sb.points_in_use();
  endtask

  task automatic put_bp(input logic [SLOT_W-1:0] slot, input logic signed [NUM_W-1:0] value);
    gen_val[slot] = value;
    offer(OP_WRITE, slot, value, sbis_side_e'($urandom_range(0, 1)));
  endtask

  task automatic ask(input logic signed [NUM_W-1:0] point, input sbis_side_e side);
    offer(OP_QUERY, SLOT_W'($urandom), point, side);
  endtask

  // Non-decreasing fill of slots 0..n-1, either spread over the whole range or clustered.
  task automatic fill_sorted(input int n);
    longint v;
    longint step_max;
    if ($urandom_range(0, 1)) begin
      v        = -(longint'(1) <<< 31) + longint'($urandom_range(0, 1 << 20));
      step_max = ((longint'(1) <<< 32) - (longint'(1) <<< 21)) / n;
    end else begin
      v        = longint'($urandom_range(0, 200000)) - 100000;
      step_max = 1000;
    end
    for (int s = 0; s < n; s++) begin
      put_bp(SLOT_W'(s), v[31:0]);
      if ($urandom_range(0, 15) != 0) v += longint'($urandom_range(1, 32'(step_max)));
    end
  endtask

  // Zero the middle slot and both edge paths of a full-depth search: a negative point
  // then walks only the left path, a positive one only the right, zero hits the middle.
  task automatic zero_edge_paths();
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = BP_DEPTH - 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      put_bp(SLOT_W'(mid), '0);
      hi = mid;
    end
    lo = (BP_DEPTH - 1) / 2;
    hi = BP_DEPTH - 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      put_bp(SLOT_W'(mid), '0);
      lo = mid;
    end
  endtask

  task automatic edge_phase(input int nq);
    logic signed [31:0] p;
    repeat (nq) begin
      case ($urandom_range(0, 3))
        0:       p = '0;
        1:       p = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        default: p = $urandom;
      endcase
      ask(p, sbis_side_e'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase(input int nq, input bit with_hold);
    int                 n;
    int                 k;
    int                 s;
    longint             v;
    logic signed [31:0] p;
    if (with_hold) hold_go <= 1'b1;
    repeat (nq) begin
      n = sb.points_in_use();
      k = $urandom_range(0, 99);
      if (k < 15) begin
        if ($urandom_range(0, 2) == 0) begin
          put_bp(SLOT_W'($urandom), $urandom);
        end else begin
          s = $urandom_range(0, n - 1);
          // keeping order only for an interior slot that wins the coin toss; otherwise the store goes unsorted
          if (s > 0 && s < n - 1 && $urandom_range(0, 1)) begin
            v = (longint'(gen_val[s-1]) + longint'(gen_val[s+1])) >>> 1;
            put_bp(SLOT_W'(s), v[31:0]);
          end else begin
            put_bp(SLOT_W'(s), $urandom);
          end
        end
      end else begin
        k = $urandom_range(0, 99);
        s = $urandom_range(0, n - 1);
        if (k < 40) p = gen_val[s];
        else if (k < 55) p = gen_val[s] + 32'($urandom_range(0, 4)) - 32'sd2;
        else if (k < 62) p = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else if (k < 70) p = $urandom_range(0, 1) ? gen_val[n-1] : gen_val[0];
        else p = $urandom;
        ask(p, sbis_side_e'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    int phase_sizes [7];
    int size;
    int drain;
    sb = new();
    foreach (gen_val[i]) gen_val[i] = '0;
    phase_sizes = '{3, 2, 17, 0, 0, 0, 200};
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    hold_go          <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_WRITE;
    in_bus.slot      <= '0;
    in_bus.number    <= '0;
    in_bus.side      <= SIDE_LEFT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two points after reset: nothing is read, answer is always 0
    ask(32'sh8000_0000, SIDE_LEFT);
    offer(OP_QUERY, 10'h3FF, 32'sh7FFF_FFFF, SIDE_RIGHT);
    ask(32'sh0000_0000, SIDE_LEFT);
    // counts below two clamp to two
    cfg_write(11'd0);
    ask(32'sh0000_3039, SIDE_RIGHT);
    cfg_write(11'd1);
    ask(32'shFFFF_FFFF, SIDE_LEFT);

    put_bp(10'd0, 32'sh8000_0000);
    put_bp(10'd1, 32'shFC18_0000);
    put_bp(10'd2, 32'shFFFF_FFFF);
    put_bp(10'd3, 32'sh0000_0000);
    put_bp(10'd4, 32'sh0000_0001);
    put_bp(10'd5, 32'sh0005_0000);
    put_bp(10'd6, 32'sh0064_0000);
    put_bp(10'd7, 32'sh7FFF_FFFF);
    cfg_write(11'd8);
    ask(gen_val[0], SIDE_RIGHT);
    ask(gen_val[7], SIDE_LEFT);
    ask(32'sh0000_0002, SIDE_LEFT);
    ask(32'shFF00_0000, SIDE_RIGHT);
    foreach (phase_sizes[i]) begin
      if (i == 0 || i == 2 || i == 4 || i == 5) begin
        ask(gen_val[i+1], SIDE_LEFT);
        ask(gen_val[i+1], SIDE_RIGHT);
      end
    end

    foreach (phase_sizes[i]) begin
      size = (phase_sizes[i] == 0) ? $urandom_range(4, 64) : phase_sizes[i];
      cfg_write(COUNT_W'(size));
      fill_sorted(sb.points_in_use());
      random_phase(60, phase_sizes[i] == 200);
    end
    // full depth: only the slots on the left and right edge paths are ever read
    cfg_write(11'd1024);
    zero_edge_paths();
    edge_phase(40);
    // above DEPTH saturates
    cfg_write(11'h7FF);
    edge_phase(20);

    quiesce();
    for (drain = 0; drain < 50000 && sb.pending() != 0; drain++) @(posedge clk_i);
    if (sb.pending() != 0)
      report_mismatch($sformatf("%0d expected intervals never arrived", sb.pending()));
    repeat (30) @(posedge clk_i);

    $display("Covered %0d breakpoint writes and %0d interval queries over %0d count settings",
             sb.writes_seen, sb.queries_seen, settings_done);
    $display("Widest search %0d points; one %0d-cycle output stall with input back-pressure",
             max_span, LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
